// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants for the 64-bit modular exponentiation block.
// Used by the controller, the datapath and the top level; no dependencies.
package mexp_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned CntW    = $clog2(DataW);
  localparam int unsigned CfgIdxW = 2;

  // Key register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegExponent = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegModulus  = CfgIdxW'(1);

  // Operations of the shared modular multiplier
  typedef enum logic [1:0] {
    OpReduce = 2'd0,
    OpMul    = 2'd1,
    OpSqr    = 2'd2
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch message, exponent copy, accumulator = 1
    logic start;      // launch the multiplier with op
    op_e  op;
    logic shift_exp;  // drop the lowest working exponent bit
    logic emit;       // move the accumulator to the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic unit_done;
    logic exp_zero;
    logic exp_bit0;
    logic exp_last;   // no set bit above bit 0
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Also reduces a single operand by feeding its bits in. Uses mexp_pkg.
module mexp_mulmod import mexp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             reduce_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  input  logic [DataW-1:0] mod_i,
  output logic             done_o,
  output logic [DataW-1:0] prod_o
);

  localparam int unsigned SumW = DataW + 3;
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] a_q, b_q, acc_q, acc_d;
  logic             reduce_q;
  logic [DataW-1:0] addend;
  logic [SumW-1:0]  sum, dif1, dif2;

  // acc = (2*acc + addend) mod m; the sum stays below 3m, so subtract m or 2m
  always_comb begin
    if (reduce_q) begin
      addend = {{(DataW-1){1'b0}}, b_q[DataW-1]};
    end else begin
      addend = b_q[DataW-1] ? a_q : '0;
    end
    sum  = {2'b00, acc_q, 1'b0} + {3'b000, addend};
    dif1 = sum - {3'b000, mod_i};
    dif2 = sum - {2'b00, mod_i, 1'b0};
    if (!dif2[SumW-1]) begin
      acc_d = dif2[DataW-1:0];
    end else if (!dif1[SumW-1]) begin
      acc_d = dif1[DataW-1:0];
    end else begin
      acc_d = sum[DataW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && (cnt_q == CntLast);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q      <= a_i;
      b_q      <= b_i;
      acc_q    <= '0;
      reduce_q <= reduce_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[DataW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still busy");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CntLast && !start_i) |=> done_q)
    else $error("final step not followed by done");
`endif

endmodule

// ===== hw/rtl/mexp_dp.sv =====
// Datapath: key registers, working exponent, base and accumulator, the
// shared modular multiplier and the output register. Uses mexp_pkg.
module mexp_dp import mexp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic [DataW-1:0]   msg_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [DataW-1:0]   out_data_o,
  input  cmd_t               cmd_i,
  output status_t            status_o
);

  logic [DataW-1:0] exponent_q, modulus_q;
  logic [DataW-1:0] exp_q, base_q, acc_q, out_data_q;
  logic             out_valid_q, out_valid_d;
  op_e              op_q;
  logic             unit_done;
  logic [DataW-1:0] unit_a, unit_b, unit_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= '0;
      modulus_q  <= DataW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegExponent) begin
        exponent_q <= cfg_data_i;
      end
      if (cfg_index_i == RegModulus) begin
        modulus_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    unit_a = base_q;
    unit_b = base_q;
    if (cmd_i.op == OpMul) begin
      unit_b = acc_q;
    end
  end

  mexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .reduce_i (cmd_i.op == OpReduce),
    .a_i      (unit_a),
    .b_i      (unit_b),
    .mod_i    (modulus_q),
    .done_o   (unit_done),
    .prod_o   (unit_prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
    end
    if (cmd_i.load) begin
      base_q <= msg_i;
      acc_q  <= DataW'(1);
    end else if (unit_done) begin
      unique case (op_q)
        OpMul:            acc_q  <= unit_prod;
        OpReduce, OpSqr:  base_q <= unit_prod;
        default:          base_q <= base_q;
      endcase
    end
    if (cmd_i.load) begin
      exp_q <= exponent_q;
    end else if (cmd_i.shift_exp) begin
      exp_q <= {1'b0, exp_q[DataW-1:1]};
    end
    if (cmd_i.emit) begin
      out_data_q <= acc_q;
    end
  end

  // Output register: filled on emit, freed when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.unit_done = unit_done;
  assign status_o.exp_zero  = (exp_q == '0);
  assign status_o.exp_bit0  = exp_q[0];
  assign status_o.exp_last  = (exp_q[DataW-1:1] == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/mexp_ctrl.sv =====
// Controller: sequences reduction, multiplies and squarings per exponent
// bit, least significant first. Uses mexp_pkg command and status types.
module mexp_ctrl import mexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SLoad = 7'b0000010,
    SRed  = 7'b0000100,
    SStep = 7'b0001000,
    SMul  = 7'b0010000,
    SSqr  = 7'b0100000,
    SOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = OpReduce;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SLoad;
        end
      end
      SLoad: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OpReduce;
        state_d     = SRed;
      end
      SRed: begin
        if (status_i.unit_done) begin
          state_d = SStep;
        end
      end
      SStep: begin
        priority if (status_i.exp_zero) begin
          state_d = SOut;
        end else if (status_i.exp_bit0) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OpMul;
          state_d     = SMul;
        end else begin
          cmd_o.start     = 1'b1;
          cmd_o.op        = OpSqr;
          cmd_o.shift_exp = 1'b1;
          state_d         = SSqr;
        end
      end
      SMul: begin
        if (status_i.unit_done) begin
          cmd_o.shift_exp = 1'b1;
          if (status_i.exp_last) begin
            // skip the squaring after the top bit
            state_d = SStep;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OpSqr;
            state_d     = SSqr;
          end
        end
      end
      SSqr: begin
        if (status_i.unit_done) begin
          state_d = SStep;
        end
      end
      SOut: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle || state_q == SOut) |-> !status_i.unit_done)
    else $error("multiplier finished with no operation pending");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result written over a waiting beat");
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == SLoad))
    else $error("accepted item not loaded");
`endif

endmodule

// ===== hw/rtl/modular_exponentiation_64.sv =====
// Modular exponentiation top level: message^exponent mod modulus, 64 bits.
// Joins mexp_ctrl and mexp_dp; types and constants from mexp_pkg.
//
// Usage:
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes the key registers: index 0 the exponent, index 1 the modulus;
//   other indexes are ignored. cfg_ready_o is always high. Write only while
//   the block is idle.
//   Input stream s_axis_* carries one message per beat, output stream
//   m_axis_* one result per beat, in order.
//   Run time rests on the bit length L of the exponent and its number P of
//   set bits: after the initial reduction of the message, the block does one
//   squaring per exponent bit below the top set bit and one multiply per set
//   bit, each on the single bit-serial multiplier. One item is worked
//   on at a time; the next message is taken once the previous result has
//   entered the output register.
//   Reset: exponent 0, modulus 1, no result pending.
//   A stalled receiver holds the result in the output register; a following
//   item is still accepted and computed, then waits until that beat leaves.
module modular_exponentiation_64 import mexp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // [63:0] message
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata    // [63:0] power_result
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .msg_i       (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== test/modular_exponentiation_64_tb.sv =====
// Self-checking testbench for modular_exponentiation_64: message^exponent mod modulus.
// Needs mexp_pkg and the block's RTL only; predicts every beat from exact 128-bit products.
module modular_exponentiation_64_tb;
  import mexp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes the block must ignore
  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);
  localparam logic [DataW-1:0]   AllOnes   = '1;
  localparam int unsigned        RandomPhases   = 7;
  localparam int unsigned        ItemsPerPhase  = 12;
  localparam int unsigned        TailCycles     = 300;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [DataW-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata  = '0;   // [63:0] message
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DataW-1:0]   m_axis_tdata;         // [63:0] power_result

  // Key copy kept in step with the block's registers
  logic [DataW-1:0] key_exponent = '0;
  logic [DataW-1:0] key_modulus  = 64'd1;

  logic [DataW-1:0] power_q[$];
  logic [DataW-1:0] expected_power;
  int unsigned      errors       = 0;
  int unsigned      items_sent   = 0;
  int unsigned      results_seen = 0;
  int unsigned      key_loads    = 0;
  int unsigned      burst_left   = 0;
  bit               sink_hold    = 1'b0;
  int unsigned      sink_mode    = 0;
  int unsigned      sink_left    = 0;

  modular_exponentiation_64 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, power_q.size());
    $display("modular_exponentiation_64_tb: FAIL");
    $finish;
  end

  // (a * b) mod m over the full 128-bit product; a zero modulus means 2^64
  function automatic logic [DataW-1:0] mul_mod_exact(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                                     logic [DataW-1:0] m);
    logic [2*DataW-1:0] prod;
    prod = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
    if (m == '0) return prod[DataW-1:0];
    return DataW'(prod % {{DataW{1'b0}}, m});
  endfunction

  // Right-to-left square-and-multiply; a zero exponent leaves the unreduced 1
  function automatic logic [DataW-1:0] predict_power(logic [DataW-1:0] msg);
    logic [DataW-1:0] e;
    logic [DataW-1:0] base;
    logic [DataW-1:0] acc;
    e    = key_exponent;
    acc  = 64'd1;
    base = (key_modulus != '0) ? msg % key_modulus : msg;
    while (e != '0) begin
      if (e[0]) begin
        acc = mul_mod_exact((key_modulus != '0) ? acc % key_modulus : acc, base, key_modulus);
      end
      e    = e >> 1;
      base = mul_mod_exact(base, base, key_modulus);
    end
    return acc;
  endfunction

  function automatic logic [DataW-1:0] pick_message(logic [DataW-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return m - 64'd1;
      2:       return m;
      3:       return AllOnes;
      4:       return DataW'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Leave cfg_valid_i high; the caller drops it after its last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegExponent) begin
      key_exponent = value;
    end else if (idx == RegModulus) begin
      key_modulus = value;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (power_q.size() != 0);
  endtask

  task automatic load_key(input logic [DataW-1:0] e, input logic [DataW-1:0] m);
    drain_results();
    write_reg(RegExponent, e);
    write_reg(RegModulus, m);
    cfg_valid_i <= 1'b0;
    key_loads++;
  endtask

  task automatic send_message(input logic [DataW-1:0] msg);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= msg;
    do @(posedge clk_i); while (!s_axis_tready);
    power_q.push_back(predict_power(msg));
    burst_left--;
    items_sent++;
  endtask

  task automatic test_reset_key();
    send_message('0);
    send_message(AllOnes);
  endtask

  task automatic test_zero_exponent();
    load_key('0, AllOnes);
    send_message('0);
    send_message(AllOnes);
    send_message({$urandom, $urandom});
  endtask

  task automatic test_unit_modulus();
    load_key({$urandom, $urandom} | 64'd1, 64'd1);
    send_message(AllOnes);
    send_message({$urandom, $urandom});
  endtask

  task automatic test_extreme_keys();
    load_key(AllOnes, AllOnes);
    send_message('0);
    send_message(64'd1);
    send_message(64'd2);
    send_message(AllOnes - 64'd1);
    send_message(AllOnes);
    load_key({1'b1, {(DataW-1){1'b0}}}, {1'b1, 31'($urandom), $urandom} | 64'd1);
    send_message({$urandom, $urandom});
    send_message(AllOnes);
    load_key(64'd1, {$urandom, $urandom} | 64'd2);
    send_message(AllOnes);
  endtask

  task automatic test_small_modulus();
    load_key(64'd3, 64'd2);
    send_message(64'd5);
    load_key(64'd65537, 64'd3);
    send_message(AllOnes);
  endtask

  task automatic test_ignored_index();
    load_key(64'd5, 64'd1000003);
    write_reg(RegSpareA, AllOnes);
    write_reg(RegSpareB, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    send_message({$urandom, $urandom});
  endtask

  // Hold the first result in the output register; the second message must still go in
  task automatic test_held_result();
    load_key(64'd3, {$urandom, $urandom} | 64'd1);
    sink_hold = 1'b1;
    send_message({$urandom, $urandom});
    send_message({$urandom, $urandom});
    sink_hold = 1'b0;
  endtask

  task automatic test_random_keys();
    logic [DataW-1:0] e;
    logic [DataW-1:0] m;
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 3))
        0:       e = {$urandom, $urandom};
        1:       e = DataW'($urandom_range(1, 65537));
        2:       e = {1'b1, 31'($urandom), $urandom};
        default: e = DataW'($urandom) << $urandom_range(0, 32);
      endcase
      case ($urandom_range(0, 3))
        0:       m = {$urandom, $urandom};
        1:       m = DataW'($urandom_range(1, 1000));
        2:       m = {1'b1, 31'($urandom), $urandom};
        default: m = {32'd0, $urandom};
      endcase
      if (m == '0) m = 64'd1;
      load_key(e, m);
      repeat (ItemsPerPhase) send_message(pick_message(m));
    end
  endtask

  // Receiver: pick a new stall behaviour whenever sink_left runs out
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(50, 600);
    end else begin
      sink_left--;
    end
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (sink_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (power_q.size() == 0) begin
        $display("%0t: unexpected power_result: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        expected_power = power_q.pop_front();
        if (m_axis_tdata !== expected_power) begin
          $display("%0t: power_result mismatch: expected %h, actual %h",
                   $time, expected_power, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_key();
    test_zero_exponent();
    test_unit_modulus();
    test_extreme_keys();
    test_small_modulus();
    test_ignored_index();
    test_held_result();
    test_random_keys();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (power_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, power_q.size());
      errors += power_q.size();
    end
    $display("Sent %0d messages under %0d key settings, %0d results checked.",
             items_sent, key_loads, results_seen);
    $display("Covered zero exponent, unit and all-ones moduli, spare indexes, held output.");
    if (errors == 0) begin
      $display("modular_exponentiation_64_tb: PASS");
    end else begin
      $display("modular_exponentiation_64_tb: FAIL");
    end
    $finish;
  end

endmodule
